### src/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// Used by every module of the block; depends on nothing.
package ffha_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 32;

  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int LINK_W  = IDX_W + 1;
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int BYTES_W = 33;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_BLOCKS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);

  localparam logic [31:0]        HDR_32 = 32'(HEADER_BYTES);
  localparam logic [BYTES_W-1:0] HDR_33 = BYTES_W'(HEADER_BYTES);
  localparam logic [47:0]        HDR_48 = 48'(HEADER_BYTES);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_BAD_FREE   = 2'd3;

  localparam logic [1:0] CFG_HEAP_BASE = 2'd0;
  localparam logic [1:0] CFG_HEAP_SIZE = 2'd1;

  typedef struct packed {
    logic        op;
    logic [31:0] req_size;
    logic [47:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [47:0]      result_address;
    logic [31:0]      used_bytes;
    logic [31:0]      free_bytes;
    logic [CNT_W-1:0] fragment_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0]       offset;
    logic [31:0]       size;
    logic [31:0]       leftover;
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
  } rec_t;

  typedef struct packed {
    logic             init;
    logic             start;
    logic             set_en;
    logic [IDX_W-1:0] set_idx;
    logic             clr_en;
    logic [IDX_W-1:0] clr_idx;
  } scan_ctl_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] slot;
  } scan_stat_t;

endpackage

### src/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: sequencer, datapath and config registers.
// Depends on ffha_pkg, ffha_rec_mem and ffha_slot_scan.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    in_item  (op, req_size, address)
//   out       output     out_valid / out_ready  out_item (status, address, stats)
//   cfg       input      cfg_write              cfg_index, cfg_data
//
// A transaction that is rejected up front (zero or oversized request, null free) goes
// straight to the result state. Otherwise the walk visits list entries, up to
// MAX_BLOCKS, until it finds its record. Unlinking a freed block adds up to 2 record
// writes. A split adds a free slot scan over up to MAX_BLOCKS-1 table entries and up
// to 3 record writes. The record memory's registered read, one record per cycle, sets
// the pace. After reset, and after each write of heap_size, the head record is
// written before in_ready rises. Results wait in an output register, so a stalled
// output does not block the next input transaction until its result is ready.
module first_fit_heap_allocator
  import ffha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [47:0] cfg_data
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WALK  = 4'd1;
  localparam logic [3:0] S_ACT   = 4'd2;
  localparam logic [3:0] S_SLOT  = 4'd3;
  localparam logic [3:0] S_WSLOT = 4'd4;
  localparam logic [3:0] S_WCUR  = 4'd5;
  localparam logic [3:0] S_WN    = 4'd6;
  localparam logic [3:0] S_WP    = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]         state, state_next;
  logic [47:0]        heap_base;
  logic [31:0]        heap_size;
  logic               init_pending;
  logic [BYTES_W-1:0] bytes_used;
  logic [CNT_W-1:0]   block_count;

  logic               op;
  logic [31:0]        req;
  logic [47:0]        address;
  logic [IDX_W-1:0]   cur;
  logic [IDX_W-1:0]   steps;
  rec_t               cur_rec;
  logic [IDX_W-1:0]   slot;
  logic [1:0]         status;
  logic               addr_ok;
  logic [31:0]        res_off;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  rec_t               wr_data;
  logic [IDX_W-1:0]   rd_addr;
  rec_t               rd_data;

  scan_ctl_t          scan_ctl;
  scan_stat_t         scan_stat;

  logic [BYTES_W-1:0] free_space;
  logic               hit;
  logic               in_fire;
  logic               fin_load;
  logic [31:0]        head_leftover;

  ffha_rec_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ffha_slot_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .ctl  (scan_ctl),
    .stat (scan_stat)
  );

  assign in_ready = (state == S_IDLE) && !init_pending;
  assign in_fire  = in_valid && in_ready;
  assign fin_load = (state == S_FIN) && (!out_valid || out_ready);

  // Free space saturates at zero; bytes_used can pass heap_size by one header.
  assign free_space = ({1'b0, heap_size} > bytes_used)
                      ? ({1'b0, heap_size} - bytes_used) : '0;

  assign head_leftover = (heap_size >= HDR_32) ? (heap_size - HDR_32) : '0;

  // The one compare the walk makes per visited record.
  always_comb begin
    if (op == OP_ALLOC) begin
      hit = {1'b0, rd_data.leftover} >= ({1'b0, req} + HDR_33);
    end else begin
      hit = (heap_base + {16'd0, rd_data.offset} + HDR_48) == address;
    end
  end

  // Memory ports and scanner control, decoded from the state.
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = cur;
    wr_data  = cur_rec;
    rd_addr  = cur;
    scan_ctl = '0;
    scan_ctl.init    = cfg_write && (cfg_index == CFG_HEAP_SIZE);
    scan_ctl.set_idx = slot;
    scan_ctl.clr_idx = cur;
    unique case (state)
      S_IDLE: begin
        rd_addr = '0;
        if (init_pending) begin
          wr_en            = 1'b1;
          wr_addr          = '0;
          wr_data.offset   = '0;
          wr_data.size     = '0;
          wr_data.leftover = head_leftover;
          wr_data.next     = NIL;
          wr_data.prev     = NIL;
        end
      end
      S_WALK: begin
        rd_addr = rd_data.next[IDX_W-1:0];
      end
      S_ACT: begin
        rd_addr = cur_rec.prev[IDX_W-1:0];
        if (op == OP_ALLOC) begin
          if (cur_rec.size == '0) begin
            wr_en            = 1'b1;
            wr_data.size     = req;
            wr_data.leftover = cur_rec.leftover - req;
          end else begin
            scan_ctl.start = 1'b1;
          end
        end else if (cur_rec.prev == NIL) begin
          wr_en            = 1'b1;
          wr_data.size     = '0;
          wr_data.leftover = cur_rec.leftover + cur_rec.size;
        end
      end
      S_SLOT: begin
      end
      S_WSLOT: begin
        wr_en            = 1'b1;
        wr_addr          = slot;
        wr_data.offset   = cur_rec.offset + cur_rec.size + HDR_32;
        wr_data.size     = req;
        wr_data.leftover = cur_rec.leftover - req - HDR_32;
        wr_data.next     = cur_rec.next;
        wr_data.prev     = {1'b0, cur};
        scan_ctl.set_en  = 1'b1;
      end
      S_WCUR: begin
        wr_en            = 1'b1;
        wr_data.leftover = '0;
        wr_data.next     = {1'b0, slot};
        rd_addr          = cur_rec.next[IDX_W-1:0];
      end
      S_WN: begin
        wr_en   = 1'b1;
        wr_addr = cur_rec.next[IDX_W-1:0];
        wr_data = rd_data;
        wr_data.prev = (op == OP_ALLOC) ? {1'b0, slot} : cur_rec.prev;
      end
      S_WP: begin
        wr_en            = 1'b1;
        wr_addr          = cur_rec.prev[IDX_W-1:0];
        wr_data          = rd_data;
        wr_data.next     = cur_rec.next;
        wr_data.leftover = rd_data.leftover + cur_rec.size + cur_rec.leftover + HDR_32;
        rd_addr          = cur_rec.next[IDX_W-1:0];
        scan_ctl.clr_en  = 1'b1;
      end
      S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (in_item.op == OP_ALLOC) begin
            if (in_item.req_size == '0 || {1'b0, in_item.req_size} > free_space) begin
              state_next = S_FIN;
            end else begin
              state_next = S_WALK;
            end
          end else if (in_item.address == '0) begin
            state_next = S_FIN;
          end else begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (hit) begin
          state_next = S_ACT;
        end else if (rd_data.next == NIL || steps == LAST_IDX) begin
          state_next = S_FIN;
        end
      end
      S_ACT: begin
        if (op == OP_ALLOC) begin
          state_next = (cur_rec.size == '0) ? S_FIN : S_SLOT;
        end else begin
          state_next = (cur_rec.prev == NIL) ? S_FIN : S_WP;
        end
      end
      S_SLOT: begin
        if (scan_stat.done) begin
          state_next = scan_stat.found ? S_WSLOT : S_FIN;
        end
      end
      S_WSLOT: state_next = S_WCUR;
      S_WCUR:  state_next = (cur_rec.next == NIL) ? S_FIN : S_WN;
      S_WN:    state_next = S_FIN;
      S_WP:    state_next = (cur_rec.next == NIL) ? S_FIN : S_WN;
      S_FIN: begin
        if (fin_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers, configuration and heap statistics.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      heap_base    <= '0;
      heap_size    <= 32'd1048576;
      init_pending <= 1'b1;
      bytes_used   <= HDR_33;
      block_count  <= CNT_W'(1);
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && init_pending) begin
        init_pending <= 1'b0;
      end
      if (cfg_write) begin
        if (cfg_index == CFG_HEAP_BASE) begin
          heap_base <= cfg_data;
        end else if (cfg_index == CFG_HEAP_SIZE) begin
          heap_size    <= cfg_data[31:0];
          init_pending <= 1'b1;
          bytes_used   <= HDR_33;
          block_count  <= CNT_W'(1);
        end
      end
      if (state == S_ACT) begin
        if (op == OP_ALLOC && cur_rec.size == '0) begin
          bytes_used <= bytes_used + {1'b0, req};
        end else if (op == OP_FREE && cur_rec.prev == NIL) begin
          bytes_used <= bytes_used - {1'b0, cur_rec.size};
        end
      end
      if (state == S_WCUR) begin
        bytes_used  <= bytes_used + {1'b0, req} + HDR_33;
        block_count <= block_count + CNT_W'(1);
      end
      if (state == S_WP) begin
        bytes_used  <= bytes_used - {1'b0, cur_rec.size} - HDR_33;
        block_count <= block_count - CNT_W'(1);
      end
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Transaction context and result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op      <= in_item.op;
      req     <= in_item.req_size;
      address <= in_item.address;
      cur     <= '0;
      steps   <= '0;
      status  <= (in_item.op == OP_ALLOC) ? ST_NO_SPACE : ST_OK;
      addr_ok <= 1'b0;
    end
    unique case (state)
      S_WALK: begin
        if (hit) begin
          cur_rec <= rd_data;
        end else begin
          cur   <= rd_data.next[IDX_W-1:0];
          steps <= steps + IDX_W'(1);
          if (rd_data.next == NIL || steps == LAST_IDX) begin
            status <= (op == OP_ALLOC) ? ST_NO_SPACE : ST_BAD_FREE;
          end
        end
      end
      S_ACT: begin
        if (op == OP_ALLOC && cur_rec.size == '0) begin
          status  <= ST_OK;
          addr_ok <= 1'b1;
          res_off <= cur_rec.offset;
        end else if (op == OP_FREE) begin
          status <= ST_OK;
        end
      end
      S_SLOT: begin
        if (scan_stat.done) begin
          slot <= scan_stat.slot;
          if (!scan_stat.found) begin
            status <= ST_TABLE_FULL;
          end
        end
      end
      S_WSLOT: begin
        status  <= ST_OK;
        addr_ok <= 1'b1;
        res_off <= wr_data.offset;
      end
      default: begin
      end
    endcase
    if (fin_load) begin
      out_item.status         <= status;
      out_item.result_address <= addr_ok ? (heap_base + {16'd0, res_off} + HDR_48) : '0;
      out_item.used_bytes     <= bytes_used[31:0];
      out_item.free_bytes     <= free_space[31:0];
      out_item.fragment_count <= block_count;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    block_count != '0 && block_count <= CNT_W'(MAX_BLOCKS))
    else $error("block count out of range");

  a_head_header: assert property (@(posedge clk) disable iff (rst)
    bytes_used >= HDR_33)
    else $error("used bytes below the head header");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input taken again while a transaction is in progress");

  a_scan_slot: assert property (@(posedge clk) disable iff (rst)
    scan_stat.done && scan_stat.found |-> scan_stat.slot != '0)
    else $error("scanner returned the head entry as free");
`endif

endmodule

### src/ffha_rec_mem.sv
// Block record memory: one write port, one read port with registered data.
// Depends on ffha_pkg for the record type and depth.
module ffha_rec_mem
  import ffha_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  rec_t             wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output rec_t             rd_data
);

  rec_t mem [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/ffha_slot_scan.sv
// In-use flags of the block table and a scanner that finds the first unused entry.
// Depends on ffha_pkg for the control and status structs.
module ffha_slot_scan
  import ffha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  scan_ctl_t  ctl,
  output scan_stat_t stat
);

  logic [MAX_BLOCKS-1:0] in_use;
  logic                  busy;
  logic [IDX_W-1:0]      idx;

  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      in_use    <= MAX_BLOCKS'(1);
      busy      <= 1'b0;
      idx       <= '0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (ctl.set_en) begin
        in_use[ctl.set_idx] <= 1'b1;
      end
      if (ctl.clr_en) begin
        in_use[ctl.clr_idx] <= 1'b0;
      end
      if (ctl.start) begin
        busy <= 1'b1;
        idx  <= IDX_W'(1);
      end else if (busy) begin
        if (!in_use[idx]) begin
          busy       <= 1'b0;
          stat.done  <= 1'b1;
          stat.found <= 1'b1;
          stat.slot  <= idx;
        end else if (idx == LAST_IDX) begin
          busy       <= 1'b0;
          stat.done  <= 1'b1;
          stat.found <= 1'b0;
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end
    end
  end

endmodule
